// File: src/fpsim_pkg.sv
// Shared types and constants for the fingerprint similarity block.
// No dependencies.
`timescale 1ns / 1ps
package fpsim_pkg;
  localparam logic [1:0] MODE_TANIMOTO  = 2'd0;
  localparam logic [1:0] MODE_EUCLIDEAN = 2'd1;
  localparam logic [1:0] MODE_TVERSKY   = 2'd2;
  localparam logic [1:0] MODE_DICE      = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_ADD   = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;
  localparam logic [1:0] REG_BETA  = 2'd3;

  localparam int NUM_W  = 40;   // widest numerator before the 2^16 or 2^32 shift
  localparam int DIV_W  = 72;   // dividend width (numerator << 32)

  // Division request handed to the shared divider
  typedef struct packed {
    logic            start;
    logic [DIV_W-1:0] dividend;
    logic [NUM_W-1:0] divisor;
  } div_req_t;
endpackage

// File: src/fingerprint_similarity.sv
// Top level of the fingerprint similarity block.
// Depends on fpsim_pkg and fpsim_div.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_stall) carries one word pair per request:
//  query_bits, target_bits, bits_used, last_word. A word that is not last
//  is counted and the block is ready again next cycle.
//  On a last word the block computes the score: numerator/denominator set
//  up (Tversky first forms the alpha product), a check of the denominator
//  (zero gives score 0 with zero_denominator set, no divide), then the
//  shared radix-2 divider loads and runs, then for Euclidean a bit-pair
//  square root. The input stalls from the last word until the result is
//  loaded and the block is idle again; the wait is set by the
//  one-bit-per-cycle divider and root loops.
//  The result sits in an output register (out_valid/out_stall); while it
//  waits the block still accepts non-last words, and a new last word
//  waits in the input until the register is free.
//  Reset clears the counters, sets registers to their defaults
//  (mode 0, add_one 1, alpha and beta 1.0) and empties the output.
//  Configuration writes (cfg_we/cfg_index/cfg_data) are registered and
//  belong only to idle periods.
module fingerprint_similarity
  import fpsim_pkg::*;
#(
  parameter int MAX_BITS  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          query_bits,
  input  logic [63:0]          target_bits,
  input  logic [6:0]           bits_used,
  input  logic                 last_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          similarity,
  output logic                 zero_denominator
);
  localparam int CW = $clog2(MAX_BITS + 1);
  localparam int PW = $clog2(WORD_BITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SET  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [1:0]  metric_mode;
  logic [7:0]  add_one;
  logic [15:0] alpha_weight, beta_weight;
  logic [CW-1:0] both_count, query_only_count, target_only_count, neither_count;
  logic [2:0]  state;
  logic [NUM_W-1:0] num, den, prod;
  logic        mul_phase;
  div_req_t    dreq;
  logic        ddone;
  logic [DIV_W-1:0] dquot;
  logic [33:0] rv, rres, rbit;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode  <= 2'd0;
      add_one      <= 8'd1;
      alpha_weight <= 16'd256;
      beta_weight  <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  metric_mode  <= cfg_data[1:0];
        REG_ADD:   add_one      <= cfg_data[7:0];
        REG_ALPHA: alpha_weight <= cfg_data;
        REG_BETA:  beta_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Masked popcounts of the incoming word pair
  logic [6:0]          used;
  logic [WORD_BITS-1:0] mask, qw, tw;
  logic [PW-1:0]       pc_s, pc_q, pc_t, pc_n;
  always_comb begin
    used = (bits_used > 7'(WORD_BITS)) ? 7'(WORD_BITS) : bits_used;
    for (int i = 0; i < WORD_BITS; i++) mask[i] = (7'(i) < used);
    qw = query_bits[WORD_BITS-1:0] & mask;
    tw = target_bits[WORD_BITS-1:0] & mask;
    pc_s = '0; pc_q = '0; pc_t = '0; pc_n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pc_s = pc_s + PW'(qw[i] & tw[i]);
      pc_q = pc_q + PW'(qw[i] & ~tw[i]);
      pc_t = pc_t + PW'(~qw[i] & tw[i]);
      pc_n = pc_n + PW'(mask[i] & ~(qw[i] | tw[i]));
    end
  end

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] a, input logic [PW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    return (s > (CW+1)'(MAX_BITS)) ? CW'(MAX_BITS) : s[CW-1:0];
  endfunction

  // Any word waits while a score is in flight; a last word also waits while a result is pending
  assign in_stall = (state != ST_IDLE) || (last_word && out_valid);
  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // Root step: trial subtrahend
  logic [33:0] rsum;
  assign rsum = rres + rbit;

  // Tversky weight products, weight times counter
  logic [15+CW:0] prod_q, prod_t;
  assign prod_q = alpha_weight * query_only_count;
  assign prod_t = beta_weight * target_only_count;

  logic [NUM_W-1:0] s_e, a_e, q_e, t_e, n_e;
  always_comb begin
    s_e = NUM_W'(both_count); q_e = NUM_W'(query_only_count);
    t_e = NUM_W'(target_only_count); n_e = NUM_W'(neither_count);
    a_e = NUM_W'(add_one);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      both_count <= '0; query_only_count <= '0;
      target_only_count <= '0; neither_count <= '0;
      dreq.start <= 1'b0;
      mul_phase <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            both_count        <= sat(both_count, pc_s);
            query_only_count  <= sat(query_only_count, pc_q);
            target_only_count <= sat(target_only_count, pc_t);
            neither_count     <= sat(neither_count, pc_n);
            if (last_word) state <= ST_MUL;
            mul_phase <= 1'b0;
          end
        end
        ST_MUL: begin
          // Build numerator and denominator; Tversky registers the alpha product first, then sums the denominator
          case (metric_mode)
            MODE_TANIMOTO: begin
              num <= s_e + a_e; den <= s_e + q_e + t_e + a_e; state <= ST_SET;
            end
            MODE_EUCLIDEAN: begin
              num <= s_e + n_e + a_e; den <= s_e + n_e + q_e + t_e + a_e;
              state <= ST_SET;
            end
            MODE_TVERSKY: begin
              if (!mul_phase) begin
                prod <= NUM_W'(prod_q);
                num  <= (s_e + a_e) << 8;
                mul_phase <= 1'b1;
              end else begin
                den <= prod + NUM_W'(prod_t) + num;
                state <= ST_SET;
              end
            end
            default: begin
              num <= (s_e << 1) + a_e; den <= q_e + t_e + (s_e << 1) + a_e;
              state <= ST_SET;
            end
          endcase
        end
        ST_SET: begin
          both_count <= '0; query_only_count <= '0;
          target_only_count <= '0; neither_count <= '0;
          if (den == '0) begin
            similarity <= '0; zero_denominator <= 1'b1;
            out_valid <= 1'b1; state <= ST_IDLE;
          end else begin
            dreq.start   <= 1'b1;
            dreq.divisor <= den;
            dreq.dividend <= (metric_mode == MODE_EUCLIDEAN) ?
                             {num, 32'd0} : DIV_W'({num, 16'd0});
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ddone) begin
            if (metric_mode == MODE_EUCLIDEAN) begin
              rv <= dquot[33:0]; rres <= '0; rbit <= 34'd1 << 32;
              state <= ST_ROOT;
            end else begin
              similarity <= dquot[16:0]; zero_denominator <= 1'b0;
              state <= ST_OUT;
            end
          end
        end
        ST_ROOT: begin
          // Digit-pair root: one result bit per cycle, no multiplier
          if (rv >= rsum) begin
            rv   <= rv - rsum;
            rres <= (rres >> 1) + rbit;
          end else begin
            rres <= rres >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit[0]) state <= ST_OUT;
        end
        ST_OUT: begin
          if (metric_mode == MODE_EUCLIDEAN) begin
            similarity <= rres[16:0]; zero_denominator <= 1'b0;
          end
          out_valid <= 1'b1; state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  fpsim_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dquot)
  );

  // Result register is only loaded when free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    both_count <= CW'(MAX_BITS)) else $error("counter overflow");
endmodule

// File: src/fpsim_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on fpsim_pkg.
`timescale 1ns / 1ps
module fpsim_div
  import fpsim_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  logic [DIV_W-1:0] dvd;
  logic [NUM_W-1:0] dvs;
  logic [NUM_W:0]   rem;
  logic [6:0]       cnt;
  logic             busy;
  logic [NUM_W:0]   trial;
  logic [NUM_W:0]   diff;

  // Shift in next dividend bit and try the subtract
  always_comb begin
    trial = {rem[NUM_W-1:0], dvd[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        dvd      <= req.dividend;
        dvs      <= req.divisor;
        rem      <= '0;
        quotient <= '0;
        cnt      <= 7'(DIV_W);
      end else if (busy) begin
        dvd <= {dvd[DIV_W-2:0], 1'b0};
        if (!diff[NUM_W]) begin
          rem      <= diff;
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= trial;
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
